FILE: rtl/csp_pkg.sv
// csp_pkg: shared types, constants and helpers of the colour string parser.
// No dependencies.
package csp_pkg;

    localparam int MAX_FRACTION_DIGITS = 8;
    localparam int NUM_W = 37;   // 510*total + p
    localparam int DEN_W = 28;   // 2*p
    localparam int POW_W = 27;   // 10^8 fits
    localparam logic [31:0] DEFAULT_ALPHA = 32'hFF00_0000;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_HEX    = 3'd1,
        MODE_PREFIX = 3'd2,
        MODE_RGB    = 3'd3,
        MODE_RGBA   = 3'd4,
        MODE_OPW    = 3'd5,
        MODE_OPF    = 3'd6,
        MODE_CLOSED = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FIN,
        SEQ_DIV
    } seq_t;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  pos;
        logic [31:0] hex_acc;
        logic [3:0]  hex_cnt;
        logic [1:0]  comp_idx;
        logic [7:0]  comp_val;
        logic        seen;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [1:0]  opw;
        logic [26:0] frac;
        logic [3:0]  fcnt;
        logic        failed;
    } parse_t;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
        else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
        else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
        return r;
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [3:0] n);
        logic [POW_W-1:0] p;
        unique case (n)
            4'd0:    p = POW_W'(1);
            4'd1:    p = POW_W'(10);
            4'd2:    p = POW_W'(100);
            4'd3:    p = POW_W'(1000);
            4'd4:    p = POW_W'(10000);
            4'd5:    p = POW_W'(100000);
            4'd6:    p = POW_W'(1000000);
            4'd7:    p = POW_W'(10000000);
            default: p = POW_W'(100000000);
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/color_string_parser.sv
// color_string_parser: top level, character parser, finish logic and output beat.
// Depends on csp_pkg and csp_div.
//
// Takes one character of a colour string per input beat (tlast marks the last
// character, tuser flags an empty string) and returns one beat per string with
// parse_ok in tuser and the ARGB word in tdata (zero on failure). Forms: '#'
// with 3, 4, 6 or 8 hex digits, "rgb(r,g,b)" and "rgba(r,g,b,o)"; spaces are
// dropped. Ordinary characters are taken back to back. After the last
// character a finish step checks the form; for rgba it then runs a restoring
// divider for round(o*255), one quotient bit a cycle, which gives the alpha
// byte of the result beat, saturated at 255. The block takes no beat while
// finishing a string, and takes no last or empty beat while a result still
// waits downstream; other characters are taken meanwhile.
module color_string_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // final_char
    input  logic        s_tuser,   // empty_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] argb_color
    output logic        m_tuser    // parse_ok
);
    import csp_pkg::*;

    seq_t        seq_reg, seq_next;
    parse_t      pst_reg, pst_next, tk;
    logic        ov_reg, ov_next;
    logic        ok_reg, ok_next;
    logic [31:0] argb_reg, argb_next;

    logic        s_fire;
    logic [7:0]  c;
    logic        is_dig;
    logic [3:0]  d;
    logic [4:0]  hv;
    logic [11:0] cv10;
    logic [30:0] fr10;
    logic        rgba;

    // finish path
    logic [23:0]        rgb;
    logic [31:0]        hex_word;
    logic               hex_ok;
    logic [POW_W-1:0]   p;
    logic [DEN_W-1:0]   total;
    logic [NUM_W-1:0]   num;
    logic               div_start, div_done;
    logic [7:0]         alpha;

    // only a beat that ends a string needs the output slot
    assign s_tready = (seq_reg == SEQ_IDLE) && (!ov_reg || m_tready || (!s_tlast && !s_tuser));
    assign s_fire   = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign is_dig   = (c >= "0") && (c <= "9");
    assign d        = 4'(c - "0");
    assign hv       = hex_value(c);
    assign cv10     = ({4'd0, pst_reg.comp_val} << 3) + ({4'd0, pst_reg.comp_val} << 1)
                      + {8'd0, d};
    assign fr10     = ({4'd0, pst_reg.frac} << 3) + ({4'd0, pst_reg.frac} << 1) + {27'd0, d};
    assign rgba     = (pst_reg.mode == MODE_RGBA);

    // One character step on the parse state.
    always_comb
    begin
        tk = pst_reg;
        unique case (pst_reg.mode)
            MODE_START:
            begin
                if (c == "#") tk.mode = MODE_HEX;
                else if (c == "r")
                begin
                    tk.mode = MODE_PREFIX;
                    tk.pos  = 3'd1;
                end
                else tk.failed = 1'b1;
            end
            MODE_HEX:
            begin
                if (!hv[4]) tk.failed = 1'b1;
                else
                begin
                    tk.hex_acc = {pst_reg.hex_acc[27:0], hv[3:0]};
                    if (pst_reg.hex_cnt != 4'd15) tk.hex_cnt = pst_reg.hex_cnt + 4'd1;
                end
            end
            MODE_PREFIX:
            begin
                if (pst_reg.pos == 3'd1 && c == "g") tk.pos = 3'd2;
                else if (pst_reg.pos == 3'd2 && c == "b") tk.pos = 3'd3;
                else if (pst_reg.pos == 3'd3 && c == "(")
                begin
                    tk.mode = MODE_RGB; tk.comp_val = 8'd0; tk.seen = 1'b0; tk.pos = 3'd0;
                end
                else if (pst_reg.pos == 3'd3 && c == "a") tk.pos = 3'd4;
                else if (pst_reg.pos == 3'd4 && c == "(")
                begin
                    tk.mode = MODE_RGBA; tk.comp_val = 8'd0; tk.seen = 1'b0; tk.pos = 3'd0;
                end
                else tk.failed = 1'b1;
            end
            MODE_RGB, MODE_RGBA:
            begin
                if (is_dig)
                begin
                    tk.comp_val = (cv10 > 12'd255) ? 8'hFF : cv10[7:0];
                    tk.seen     = 1'b1;
                end
                else if (c == "+")
                begin
                    if (pst_reg.seen || pst_reg.pos != 3'd0) tk.failed = 1'b1;
                    else tk.pos = 3'd1;
                end
                else if (c == ",")
                begin
                    if (!pst_reg.seen || (pst_reg.comp_idx == 2'd2 && !rgba)) tk.failed = 1'b1;
                    else
                    begin
                        case (pst_reg.comp_idx)
                            2'd0:    tk.red   = pst_reg.comp_val;
                            2'd1:    tk.green = pst_reg.comp_val;
                            default: tk.blue  = pst_reg.comp_val;
                        endcase
                        tk.comp_idx = pst_reg.comp_idx + 2'd1;
                        tk.comp_val = 8'd0;
                        tk.seen     = 1'b0;
                        tk.pos      = 3'd0;
                        if (pst_reg.comp_idx == 2'd2) tk.mode = MODE_OPW;
                    end
                end
                else if (c == ")")
                begin
                    if (rgba || !pst_reg.seen || pst_reg.comp_idx != 2'd2) tk.failed = 1'b1;
                    else
                    begin
                        tk.blue = pst_reg.comp_val;
                        tk.mode = MODE_CLOSED;
                    end
                end
                else tk.failed = 1'b1;
            end
            MODE_OPW:
            begin
                if (is_dig)
                begin
                    if (pst_reg.opw == 2'd0) tk.opw = (d > 4'd1) ? 2'd2 : {1'b0, d[0]};
                    else tk.opw = 2'd2;
                    tk.seen = 1'b1;
                end
                else if (c == "." && pst_reg.seen) tk.mode = MODE_OPF;
                else if (c == ")" && pst_reg.seen) tk.mode = MODE_CLOSED;
                else tk.failed = 1'b1;
            end
            MODE_OPF:
            begin
                if (is_dig)
                begin
                    if (pst_reg.opw == 2'd1 && d != 4'd0) tk.opw = 2'd2;
                    if (pst_reg.fcnt < 4'(MAX_FRACTION_DIGITS))
                    begin
                        tk.frac = fr10[26:0];
                        tk.fcnt = pst_reg.fcnt + 4'd1;
                    end
                end
                else if (c == ")") tk.mode = MODE_CLOSED;
                else tk.failed = 1'b1;
            end
            default: tk.failed = 1'b1;
        endcase
    end

    // Finish terms, from the registered parse state.
    assign rgb = {pst_reg.red, pst_reg.green, pst_reg.blue};
    always_comb
    begin
        hex_ok   = 1'b1;
        hex_word = 32'd0;
        case (pst_reg.hex_cnt)
            4'd6: hex_word = pst_reg.hex_acc | DEFAULT_ALPHA;
            4'd8: hex_word = pst_reg.hex_acc;
            4'd3: hex_word = {8'hFF,
                              {2{pst_reg.hex_acc[11:8]}},
                              {2{pst_reg.hex_acc[7:4]}},
                              {2{pst_reg.hex_acc[3:0]}}};
            4'd4: hex_word = {{2{pst_reg.hex_acc[15:12]}},
                              {2{pst_reg.hex_acc[11:8]}},
                              {2{pst_reg.hex_acc[7:4]}},
                              {2{pst_reg.hex_acc[3:0]}}};
            default: hex_ok = 1'b0;
        endcase
    end

    assign p     = pow10(pst_reg.fcnt);
    assign total = pst_reg.opw[0] ? ({1'b0, p} + {1'b0, pst_reg.frac})
                                  : {1'b0, pst_reg.frac};
    // 2*total*255 + p over 2*p
    assign num   = ({9'd0, total} << 9) - ({9'd0, total} << 1) + {10'd0, p};

    csp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   ({p, 1'b0}),
        .done  (div_done),
        .quot  (alpha)
    );

    // Sequencer and output beat.
    always_comb
    begin
        seq_next  = seq_reg;
        pst_next  = pst_reg;
        ov_next   = ov_reg;
        ok_next   = ok_reg;
        argb_next = argb_reg;
        div_start = 1'b0;
        if (ov_reg && m_tready) ov_next = 1'b0;
        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_tuser)
                    begin
                        pst_next  = '0;
                        ov_next   = 1'b1;
                        ok_next   = 1'b0;
                        argb_next = 32'd0;
                    end
                    else
                    begin
                        if (c != " " && !pst_reg.failed) pst_next = tk;
                        if (s_tlast) seq_next = SEQ_FIN;
                    end
                end
            end
            SEQ_FIN:
            begin
                seq_next  = SEQ_IDLE;
                pst_next  = '0;
                ov_next   = 1'b1;
                ok_next   = 1'b0;
                argb_next = 32'd0;
                if (!pst_reg.failed)
                begin
                    if (pst_reg.mode == MODE_HEX && hex_ok)
                    begin
                        ok_next   = 1'b1;
                        argb_next = hex_word;
                    end
                    else if (pst_reg.mode == MODE_CLOSED && pst_reg.comp_idx != 2'd3)
                    begin
                        ok_next   = 1'b1;
                        argb_next = DEFAULT_ALPHA | {8'd0, rgb};
                    end
                    else if (pst_reg.mode == MODE_CLOSED && pst_reg.opw[1] == 1'b0)
                    begin
                        // rgba: keep state, run the divider
                        seq_next  = SEQ_DIV;
                        pst_next  = pst_reg;
                        ov_next   = 1'b0;
                        div_start = 1'b1;
                    end
                end
            end
            SEQ_DIV:
            begin
                if (div_done)
                begin
                    seq_next  = SEQ_IDLE;
                    pst_next  = '0;
                    ov_next   = 1'b1;
                    ok_next   = 1'b1;
                    argb_next = {alpha, rgb};
                end
            end
            default: seq_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SEQ_IDLE;
            pst_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            seq_reg <= seq_next;
            pst_reg <= pst_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg   <= ok_next;
        argb_reg <= argb_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = argb_reg;

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !ok_reg |-> argb_reg == 32'd0)
        else $error("failed parse with nonzero colour");
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> seq_reg == SEQ_DIV)
        else $error("divider result outside divide step");
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SEQ_FIN |-> !ov_reg)
        else $error("finish with output slot still full");
    a_fin_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SEQ_FIN |-> $past(s_fire && s_tlast && !s_tuser))
        else $error("finish without a last beat");

endmodule

FILE: rtl/csp_div.sv
// csp_div: restoring divider giving the 8-bit alpha quotient, one bit a cycle.
// Depends on csp_pkg.
module csp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [csp_pkg::NUM_W-1:0] num,
    input  logic [csp_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [7:0]                quot
);
    import csp_pkg::*;

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [8:0]       q_reg, q_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = NUM_W'({den, 8'd0});
            q_next    = 9'd0;
            cnt_next  = 4'd9;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[7:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[7:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg[8] ? 8'hFF : q_reg[7:0];

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !done_next |=> busy_reg || done_reg)
        else $error("divider dropped a run");
    a_count_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> cnt_reg == 4'd0)
        else $error("divider finished early");

endmodule
